// ===== hw/rtl/vds_pkg.sv =====
`timescale 1ns / 1ps
// vds_pkg: shared types and constants of the velocity direction sector block.
// Holds the CORDIC arctangent table and the fixed field widths. No dependencies.
package vds_pkg;

  localparam int GUARD_BITS   = 24;
  localparam int CORDIC_ITERS = 28;
  localparam int ACC_W        = 32;
  localparam int CNT_W        = 7;
  localparam int FRAME_W      = 6;

  localparam logic [CNT_W-1:0] SECTOR_RESET = 7'd8;
  localparam logic [ACC_W-1:0] HALF_TURN    = 32'h8000_0000;

  typedef logic [ACC_W-1:0]   acc_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [FRAME_W-1:0] frame_t;

  // Valid and zero-vector flag travel together down the cell chain.
  typedef struct packed {
    logic valid;
    logic zero;
  } vds_ctl_t;

  // atan(2^-i) in units of 2^-32 turn, truncated.
  localparam acc_t ATAN_TURNS [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005
  };

endpackage

// ===== hw/rtl/velocity_direction_sector.sv =====
`timescale 1ns / 1ps
// velocity_direction_sector: top level, a chain of CORDIC cells plus quantizer.
// Depends on vds_pkg, vds_cell and vds_quant.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one velocity vector per beat,
//   in_vel_x and in_vel_y in two's complement. Output channel
//   (out_valid/out_ready) returns one beat per input: out_frame_index, the
//   nearest of N equal direction sectors (sector 0 centered on +y, counting
//   toward +x), and out_no_frames when N is zero. A zero vector maps to 0.
//   Config channel (cfg_valid/cfg_ready) writes sector_count; it is always
//   ready and must only be written while no beat is in flight. Counts above
//   MAX_SECTORS act as MAX_SECTORS.
// Pipeline: one pre-rotation register, 28 CORDIC cells and one output register
//   between the input beat and out_valid.
// Throughput: one beat per cycle while the skid register is empty; every cell
//   advances each cycle the chain is enabled.
// Stall: a one-beat skid register behind the output register absorbs the
//   beat in flight; while it holds data the whole chain freezes and in_ready
//   is low. in_ready comes from a register only.
// Reset: sector_count returns to 8, all valid flags clear, nothing in flight.
module velocity_direction_sector #(
  parameter int VEL_WIDTH   = 16,
  parameter int ANGLE_BITS  = 16,
  parameter int MAX_SECTORS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VEL_WIDTH-1:0]   in_vel_x,
  input  logic signed [VEL_WIDTH-1:0]   in_vel_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output vds_pkg::frame_t               out_frame_index,
  output logic                          out_no_frames,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  vds_pkg::cnt_t                 cfg_sector_count
);
  import vds_pkg::*;

  // Scaled vector plus headroom for CORDIC gain (about 2.33x of |y|,|x|).
  localparam int DW = VEL_WIDTH + GUARD_BITS + 3;

  cnt_t sector_count_r;

  logic                 adv;
  logic signed [DW-1:0] x_ext, y_ext;
  logic signed [DW-1:0] s0_u_nxt, s0_v_nxt;
  acc_t                 s0_acc_nxt;

  // Chain taps: index 0 is the pre-rotation register, index i+1 is cell i.
  vds_ctl_t             ch_ctl [CORDIC_ITERS+1];
  logic signed [DW-1:0] ch_u   [CORDIC_ITERS+1];
  logic signed [DW-1:0] ch_v   [CORDIC_ITERS+1];
  acc_t                 ch_acc [CORDIC_ITERS+1];

  vds_ctl_t             s0_ctl_r;
  logic signed [DW-1:0] s0_u_r, s0_v_r;
  acc_t                 s0_acc_r;

  frame_t q_frame;
  logic   q_none;

  logic   out_valid_r, out_valid_nxt;
  frame_t out_frame_r, out_frame_nxt;
  logic   out_none_r, out_none_nxt;
  logic   skid_valid_r, skid_valid_nxt;
  frame_t skid_frame_r, skid_frame_nxt;
  logic   skid_none_r, skid_none_nxt;

  // Config register: always ready; the user must write it only while idle, the block does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_count_r <= SECTOR_RESET;
    end else if (cfg_valid) begin
      sector_count_r <= cfg_sector_count;
    end
  end

  // Advance the chain whenever the skid register is empty.
  assign adv      = !skid_valid_r;
  assign in_ready = adv;

  // Pre-rotation: scale by the guard bits, fold the lower half plane by a
  // half turn so the first micro-rotation starts with u >= 0.
  assign x_ext = DW'(in_vel_x) <<< GUARD_BITS;
  assign y_ext = DW'(in_vel_y) <<< GUARD_BITS;

  always_comb begin
    if (in_vel_y[VEL_WIDTH-1]) begin
      s0_u_nxt   = -y_ext;
      s0_v_nxt   = -x_ext;
      s0_acc_nxt = HALF_TURN;
    end else begin
      s0_u_nxt   = y_ext;
      s0_v_nxt   = x_ext;
      s0_acc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      s0_ctl_r.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ctl_r.zero <= (in_vel_x == '0) && (in_vel_y == '0);
      s0_u_r        <= s0_u_nxt;
      s0_v_r        <= s0_v_nxt;
      s0_acc_r      <= s0_acc_nxt;
    end
  end

  assign ch_ctl[0] = s0_ctl_r;
  assign ch_u[0]   = s0_u_r;
  assign ch_v[0]   = s0_v_r;
  assign ch_acc[0] = s0_acc_r;

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cell
    vds_cell #(
      .STAGE (i),
      .DW    (DW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .ctl_in  (ch_ctl[i]),
      .u_in    (ch_u[i]),
      .v_in    (ch_v[i]),
      .acc_in  (ch_acc[i]),
      .ctl_out (ch_ctl[i+1]),
      .u_out   (ch_u[i+1]),
      .v_out   (ch_v[i+1]),
      .acc_out (ch_acc[i+1])
    );
  end

  vds_quant #(
    .ANGLE_BITS  (ANGLE_BITS),
    .MAX_SECTORS (MAX_SECTORS)
  ) u_quant (
    .acc          (ch_acc[CORDIC_ITERS]),
    .zero         (ch_ctl[CORDIC_ITERS].zero),
    .sector_count (sector_count_r),
    .frame_index  (q_frame),
    .no_frames    (q_none)
  );

  // Output register with skid: when the receiver stalls, park the beat
  // leaving the chain and freeze the chain until the skid drains.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_frame_nxt  = out_frame_r;
    out_none_nxt   = out_none_r;
    skid_valid_nxt = skid_valid_r;
    skid_frame_nxt = skid_frame_r;
    skid_none_nxt  = skid_none_r;
    if (skid_valid_r) begin
      if (out_ready) begin
        out_valid_nxt  = 1'b1;
        out_frame_nxt  = skid_frame_r;
        out_none_nxt   = skid_none_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (out_valid_r && !out_ready) begin
      skid_valid_nxt = ch_ctl[CORDIC_ITERS].valid;
      skid_frame_nxt = q_frame;
      skid_none_nxt  = q_none;
    end else begin
      out_valid_nxt = ch_ctl[CORDIC_ITERS].valid;
      out_frame_nxt = q_frame;
      out_none_nxt  = q_none;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_frame_r  <= out_frame_nxt;
    out_none_r   <= out_none_nxt;
    skid_frame_r <= skid_frame_nxt;
    skid_none_r  <= skid_none_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_frame_index = out_frame_r;
  assign out_no_frames   = out_none_r;

endmodule

// ===== hw/rtl/vds_cell.sv =====
`timescale 1ns / 1ps
// vds_cell: one vectoring CORDIC micro-rotation with its stage register.
// Depends on vds_pkg for the arctangent table and the control struct.
module vds_cell #(
  parameter int STAGE = 0,
  parameter int DW    = 43
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  vds_pkg::vds_ctl_t     ctl_in,
  input  logic signed [DW-1:0]  u_in,
  input  logic signed [DW-1:0]  v_in,
  input  vds_pkg::acc_t         acc_in,
  output vds_pkg::vds_ctl_t     ctl_out,
  output logic signed [DW-1:0]  u_out,
  output logic signed [DW-1:0]  v_out,
  output vds_pkg::acc_t         acc_out
);
  import vds_pkg::*;

  vds_ctl_t             ctl_r;
  logic signed [DW-1:0] u_r, u_nxt;
  logic signed [DW-1:0] v_r, v_nxt;
  acc_t                 acc_r, acc_nxt;
  logic signed [DW-1:0] du, dv;

  // Arithmetic shift rounds toward minus infinity.
  assign du = v_in >>> STAGE;
  assign dv = u_in >>> STAGE;

  always_comb begin
    if (!v_in[DW-1]) begin
      u_nxt   = u_in + du;
      v_nxt   = v_in - dv;
      acc_nxt = acc_in + ATAN_TURNS[STAGE];
    end else begin
      u_nxt   = u_in - du;
      v_nxt   = v_in + dv;
      acc_nxt = acc_in - ATAN_TURNS[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.zero <= ctl_in.zero;
      u_r        <= u_nxt;
      v_r        <= v_nxt;
      acc_r      <= acc_nxt;
    end
  end

  assign ctl_out = ctl_r;
  assign u_out   = u_r;
  assign v_out   = v_r;
  assign acc_out = acc_r;

endmodule

// ===== hw/rtl/vds_quant.sv =====
`timescale 1ns / 1ps
// vds_quant: rounds the CORDIC turn accumulator to the angle and picks the sector.
// Depends on vds_pkg for widths and types.
module vds_quant #(
  parameter int ANGLE_BITS  = 16,
  parameter int MAX_SECTORS = 64
) (
  input  vds_pkg::acc_t   acc,
  input  logic            zero,
  input  vds_pkg::cnt_t   sector_count,
  output vds_pkg::frame_t frame_index,
  output logic            no_frames
);
  import vds_pkg::*;

  localparam int NW   = $clog2(MAX_SECTORS + 1);
  localparam int CMPW = (NW > CNT_W) ? NW : CNT_W;
  localparam int PW   = ANGLE_BITS + NW + 1;

  logic [CMPW-1:0]       cnt_ext;
  logic [NW-1:0]         n_eff;
  acc_t                  acc_rnd;
  logic [ANGLE_BITS-1:0] angle;
  logic [PW-1:0]         prod;
  logic [NW:0]           sector;

  always_comb begin
    cnt_ext = CMPW'(sector_count);
    if (cnt_ext > CMPW'(MAX_SECTORS)) begin
      n_eff = NW'(MAX_SECTORS);
    end else begin
      n_eff = NW'(cnt_ext);
    end
  end

  // Round to nearest, half up, wrapping modulo one turn.
  assign acc_rnd = acc + (ACC_W'(1) << (ACC_W - 1 - ANGLE_BITS));
  assign angle   = zero ? '0 : acc_rnd[ACC_W-1 -: ANGLE_BITS];

  assign prod   = PW'(angle) * PW'(n_eff) + (PW'(1) << (ANGLE_BITS - 1));
  assign sector = prod[PW-1 -: (NW + 1)];

  always_comb begin
    no_frames = (n_eff == '0);
    if (no_frames || (sector >= (NW + 1)'(n_eff))) begin
      frame_index = '0;
    end else begin
      frame_index = FRAME_W'(sector);
    end
  end

endmodule

// ===== sim/vds_sector_checker.sv =====
`timescale 1ns / 1ps
// vds_sector_checker: scoreboard for velocity_direction_sector. Watches the three channels,
// predicts each frame from its own CORDIC model and compares. Depends on vds_pkg.
module vds_sector_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  vds_pkg::frame_t    out_frame_index,
  input  logic               out_no_frames,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  vds_pkg::cnt_t      cfg_sector_count,
  output int                 mismatch_count,
  output int                 beats_pending
);
  import vds_pkg::*;

  localparam int SECTOR_CAP  = 64;
  localparam int ANGLE_SHIFT = 16;

  typedef struct packed {
    frame_t frame;
    logic   no_frames;
  } sector_beat_t;

  sector_beat_t pending_sectors[$];
  cnt_t         sector_cfg = SECTOR_RESET;

  // Vectoring CORDIC: bearing from +y toward +x as a 32-bit fraction of a turn.
  function automatic acc_t vector_turns(logic signed [15:0] vx, logic signed [15:0] vy);
    longint u;
    longint v;
    longint du;
    longint dv;
    acc_t   acc;
    u   = longint'(vy) <<< GUARD_BITS;
    v   = longint'(vx) <<< GUARD_BITS;
    acc = '0;
    if (u < 0) begin
      u   = -u;
      v   = -v;
      acc = HALF_TURN;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      du = v >>> i;
      dv = u >>> i;
      if (v >= 0) begin
        u   = u + du;
        v   = v - dv;
        acc = acc + ATAN_TURNS[i];
      end else begin
        u   = u - du;
        v   = v + dv;
        acc = acc - ATAN_TURNS[i];
      end
    end
    return acc;
  endfunction

  function automatic sector_beat_t predict_sector(logic signed [15:0] vx,
                                                  logic signed [15:0] vy, cnt_t cfg);
    sector_beat_t    beat;
    longint unsigned n;
    longint unsigned bearing;
    longint unsigned sector;
    beat = '0;
    n    = (cfg > SECTOR_CAP) ? SECTOR_CAP : cfg;
    if (n == 0) begin
      beat.no_frames = 1'b1;
      return beat;
    end
    bearing = 0;
    if (vx != 0 || vy != 0)
      bearing = (({32'd0, vector_turns(vx, vy)} + 64'd32768) >> ANGLE_SHIFT) & 64'hFFFF;
    // halfway rounds up; the top sector wraps back to 0
    sector = (bearing * n + 64'd32768) >> ANGLE_SHIFT;
    if (sector >= n)
      sector = 0;
    beat.frame = sector[FRAME_W-1:0];
    return beat;
  endfunction

  task automatic note_mismatch(string what, sector_beat_t want);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: frame %0d no_frames %0d, wanted frame %0d no_frames %0d",
               $realtime, what, out_frame_index, out_no_frames, want.frame, want.no_frames);
  endtask

  initial begin
    mismatch_count = 0;
    beats_pending  = 0;
  end

  always @(posedge clk) begin
    sector_beat_t want;
    if (!rst_n) begin
      sector_cfg = SECTOR_RESET;
      pending_sectors.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        sector_cfg = cfg_sector_count;
      if (in_valid && in_ready)
        pending_sectors.push_back(predict_sector(in_vel_x, in_vel_y, sector_cfg));
      if (out_valid && out_ready) begin
        if (pending_sectors.size() == 0) begin
          note_mismatch("unrequested beat", '0);
        end else begin
          want = pending_sectors.pop_front();
          if (out_frame_index !== want.frame || out_no_frames !== want.no_frames)
            note_mismatch("wrong beat", want);
        end
      end
    end
    beats_pending = pending_sectors.size();
  end

endmodule

// ===== sim/velocity_direction_sector_tb.sv =====
`timescale 1ns / 1ps
// velocity_direction_sector_tb: stimulus and verdict for the direction sector block.
// Depends on vds_pkg, velocity_direction_sector and vds_sector_checker.
module velocity_direction_sector_tb;
  import vds_pkg::*;

  // Pipeline is 30 deep; pad it for the drain before a config write and at the end.
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BEATS = 115;
  localparam int LONG_HOLD    = 400;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_vel_x;
  logic signed [15:0] in_vel_y;
  logic               out_valid;
  logic               out_ready;
  frame_t             out_frame_index;
  logic               out_no_frames;
  logic               cfg_valid;
  logic               cfg_ready;
  cnt_t               cfg_sector_count;

  int mismatch_count;
  int beats_pending;
  int max_gap      = 6;  // shared idle bound for both sides; 0 gives a back-to-back stretch
  int ready_hold   = 0;  // one-shot long stall request for the output side

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  velocity_direction_sector dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_vel_x        (in_vel_x),
    .in_vel_y        (in_vel_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_index (out_frame_index),
    .out_no_frames   (out_no_frames),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_sector_count(cfg_sector_count)
  );

  vds_sector_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_vel_x        (in_vel_x),
    .in_vel_y        (in_vel_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_index (out_frame_index),
    .out_no_frames   (out_no_frames),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_sector_count(cfg_sector_count),
    .mismatch_count  (mismatch_count),
    .beats_pending   (beats_pending)
  );

  // Offer one vector beat. Called at a falling edge; returns at the falling edge
  // after acceptance with in_valid still high, so a zero gap keeps valid asserted
  // and only the payload moves.
  task automatic send_vector(logic signed [15:0] vx, logic signed [15:0] vy);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_vel_x <= vx;
    in_vel_y <= vy;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid, let every outstanding beat come back, then let the pipe drain.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (beats_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write sector_count; only called on an idle block.
  task automatic write_sector_count(cnt_t count);
    wait_drained();
    cfg_valid        <= 1'b1;
    cfg_sector_count <= count;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Axis directions and the two diagonals: with N of 1, 2 or 4 some of these
  // land exactly halfway between sector centers.
  task automatic send_axes();
    send_vector(16'sd0, 16'sd1);
    send_vector(16'sd1, 16'sd0);
    send_vector(16'sd0, -16'sd1);
    send_vector(-16'sd1, 16'sd0);
    send_vector(16'sd5, 16'sd5);
    send_vector(16'sd5, -16'sd5);
    send_vector(-16'sd5, -16'sd5);
    send_vector(-16'sd5, 16'sd5);
  endtask

  // Mix of shapes: half full-range vectors, the rest tiny, near-axis, diagonal,
  // rail-to-rail and down-scaled ones to vary magnitude and bearing.
  task automatic random_vector(output logic signed [15:0] vx, output logic signed [15:0] vy);
    int   shape;
    logic signed [15:0] mag;
    shape = $urandom_range(0, 9);
    vx    = 16'($urandom());
    vy    = 16'($urandom());
    case (shape)
      5: begin
        vx = 16'($signed($urandom_range(0, 8)) - 4);
        vy = 16'($signed($urandom_range(0, 8)) - 4);
      end
      6: begin
        if ($urandom_range(0, 1)) vx = 16'($signed($urandom_range(0, 2)) - 1);
        else                      vy = 16'($signed($urandom_range(0, 2)) - 1);
      end
      7: begin
        mag = 16'($urandom_range(1, 32767));
        vx  = $urandom_range(0, 1) ? mag : -mag;
        vy  = $urandom_range(0, 1) ? mag : -mag;
      end
      8: begin
        if ($urandom_range(0, 1)) vx = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        if ($urandom_range(0, 1)) vy = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
      9: begin
        vx = vx >>> $urandom_range(0, 15);
        vy = vy >>> $urandom_range(0, 15);
      end
      default: ;
    endcase
  endtask

  // Output side: per beat, idle a random gap up to max_gap, then hold ready until a beat
  // moves. A pending long-hold request is served first, counted here.
  initial begin
    int gap;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        repeat (ready_hold) @(negedge clk);
        ready_hold = 0;
      end
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("velocity_direction_sector_tb: errors");
    $finish;
  end

  initial begin
    cnt_t               phase_counts [10];
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    // 0 means no frames; 127 and 65 exceed the cap and act as 64.
    phase_counts = '{7'd1, 7'd2, 7'd0, 7'd64, 7'd127, 7'd3, 7'd65, 7'd13, 7'd36, 7'd8};
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_vel_x         = '0;
    in_vel_y         = '0;
    cfg_valid        = 1'b0;
    cfg_sector_count = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats under the reset count of 8: zero vector, rails, unit steps.
    send_vector(16'sd0, 16'sd0);
    send_axes();
    send_vector(16'sh7FFF, 16'sh7FFF);
    send_vector(16'sh8000, 16'sh8000);
    send_vector(16'sh7FFF, 16'sh8000);
    send_vector(16'sh8000, 16'sh7FFF);
    send_vector(16'sh7FFF, 16'sd0);
    send_vector(16'sd0, 16'sh8000);
    send_vector(16'sh8000, 16'sd0);
    send_vector(16'sd0, 16'sh7FFF);
    send_vector(-16'sd1, -16'sd1);
    send_vector(16'sh5555, -16'sh2AAB);
    send_vector(-16'sh5556, 16'sh2AAA);

    foreach (phase_counts[p]) begin
      write_sector_count(phase_counts[p]);
      // Every third phase runs without idling on either side.
      max_gap = (p % 3 == 2) ? 0 : 6;
      // Stall the output long enough to fill the pipe and back up the input.
      if (phase_counts[p] == 7'd64)
        ready_hold = LONG_HOLD;
      send_vector(16'sd0, 16'sd0);
      send_axes();
      repeat (RANDOM_BEATS) begin
        random_vector(rx, ry);
        send_vector(rx, ry);
      end
    end

    wait_drained();
    if (mismatch_count == 0)
      $display("velocity_direction_sector_tb: clean");
    else
      $display("velocity_direction_sector_tb: errors");
    $finish;
  end

endmodule
